>>> design/fmd_pkg.sv
// shared types and constants for the framed message deframer
package fmd_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SENDER_W = 5;
  localparam int unsigned LEN_W    = 3;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  // bits per byte, the saturation point of the bit counter
  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // register reset values
  localparam logic [BYTE_W-1:0] SYNC_RESET  = 8'd65;
  localparam logic [BYTE_W-1:0] START_RESET = 8'd66;
  localparam logic [BYTE_W-1:0] END_RESET   = 8'd67;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC  = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;
  localparam int unsigned CFG_ADDR_W = 2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  // receive phase
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_START  = 3'd1,
    PH_HEADER = 3'd2,
    PH_DATA   = 3'd3,
    PH_END    = 3'd4
  } phase_t;

  // framing bytes handed to the core
  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic                kind;
    logic [SENDER_W-1:0] sender_id;
    logic [BYTE_W-1:0]   data;
  } res_t;

endpackage

>>> design/fmd_core.sv
// bit window, byte counter and framing state machine
module fmd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bit_fire,
  input  logic          rx_bit,
  input  fmd_pkg::cfg_t cfg,
  output logic          res_valid,
  output fmd_pkg::res_t res
);

  logic [fmd_pkg::BYTE_W-1:0]   window_r, window_nxt;
  logic [fmd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  fmd_pkg::phase_t              phase_r, phase_nxt;
  logic [fmd_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [fmd_pkg::LEN_W-1:0]    taken_r, taken_nxt, taken_inc;
  logic [fmd_pkg::SENDER_W-1:0] sender_r, sender_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      cnt_r    <= '0;
      phase_r  <= fmd_pkg::PH_HUNT;
      len_r    <= '0;
      taken_r  <= '0;
      sender_r <= '0;
    end else begin
      window_r <= window_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      taken_r  <= taken_nxt;
      sender_r <= sender_nxt;
    end
  end

  assign cnt_inc   = (cnt_r < fmd_pkg::BITS_PER_BYTE) ? cnt_r + 4'd1 : cnt_r;
  assign taken_inc = taken_r + 3'd1;

  // next state and result for one bit
  always_comb begin
    window_nxt = window_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    taken_nxt  = taken_r;
    sender_nxt = sender_r;
    res_valid  = 1'b0;
    res.kind      = fmd_pkg::KIND_PAYLOAD;
    res.data      = '0;
    res.sender_id = sender_r;
    if (bit_fire) begin
      window_nxt = {window_r[fmd_pkg::BYTE_W-2:0], rx_bit};
      cnt_nxt    = cnt_inc;
      if (cnt_inc == fmd_pkg::BITS_PER_BYTE) begin
        case (phase_r)
          fmd_pkg::PH_START: begin
            if (window_nxt == cfg.start_byte) begin
              cnt_nxt   = '0;
              phase_nxt = fmd_pkg::PH_HEADER;
            end else begin
              phase_nxt = fmd_pkg::PH_HUNT;
              taken_nxt = '0;
              len_nxt   = '0;
            end
          end
          fmd_pkg::PH_HEADER: begin
            // upper bits carry the sender, lower bits the length
            sender_nxt = window_nxt[fmd_pkg::BYTE_W-1:fmd_pkg::LEN_W];
            len_nxt    = window_nxt[fmd_pkg::LEN_W-1:0];
            taken_nxt  = '0;
            cnt_nxt    = '0;
            phase_nxt  = (window_nxt[fmd_pkg::LEN_W-1:0] == '0) ? fmd_pkg::PH_END
                                                                 : fmd_pkg::PH_DATA;
          end
          fmd_pkg::PH_DATA: begin
            res_valid = 1'b1;
            res.kind  = fmd_pkg::KIND_PAYLOAD;
            res.data  = window_nxt;
            taken_nxt = taken_inc;
            cnt_nxt   = '0;
            if (taken_inc == len_r || taken_inc == '0) begin
              phase_nxt = fmd_pkg::PH_END;
            end
          end
          fmd_pkg::PH_END: begin
            if (window_nxt == cfg.end_byte) begin
              res_valid = 1'b1;
              res.kind  = fmd_pkg::KIND_FRAME;
              cnt_nxt   = '0;
            end
            phase_nxt = fmd_pkg::PH_HUNT;
            taken_nxt = '0;
            len_nxt   = '0;
          end
          default: begin
            // hunting: compare at every bit
            if (window_nxt == cfg.sync_byte) begin
              cnt_nxt   = '0;
              phase_nxt = fmd_pkg::PH_START;
            end else begin
              phase_nxt = fmd_pkg::PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // counter saturates at one byte
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= fmd_pkg::BITS_PER_BYTE)
    else $error("bit counter above byte size");

  // payload count never runs past the header length
  assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= len_r)
    else $error("payload count beyond length");

  // results only come out of the payload or end phases
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == fmd_pkg::PH_DATA || phase_r == fmd_pkg::PH_END))
    else $error("result outside payload or end phase");

  // the bit counter is cleared after a payload beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == fmd_pkg::KIND_PAYLOAD) |=> (cnt_r == '0))
    else $error("counter not cleared after payload beat");

endmodule

>>> design/fmd_obuf.sv
// two-entry output register with skid stage
module fmd_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fmd_pkg::res_t push_res,
  output logic          push_ready,
  output logic          out_valid,
  output fmd_pkg::res_t out_res,
  input  logic          out_ready
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  fmd_pkg::res_t out_res_r, out_res_nxt;
  fmd_pkg::res_t skid_res_r, skid_res_nxt;
  logic          pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload holds
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  // fill and drain
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_res_nxt   = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // skid entry only ever sits behind a full output register
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  // a stalled full buffer keeps both entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> skid_valid_r)
    else $error("skid entry lost while stalled");

endmodule

>>> design/framed_message_deframer.sv
// framed message deframer top level: config registers, core and output buffer
//
// Recovers framed messages from a serial bit stream. Each input beat on the
// in_ channel carries one received bit (in_tdata[0]), most significant first.
// The block hunts for the sync byte at every bit, then expects the start
// byte, a header (sender id in the upper 5 bits, payload length in the lower
// 3), the payload bytes and the end byte.
// Each payload byte comes out as a beat with out_tuser low; a frame closed by
// a matching end byte comes out as a beat with out_tuser high and a zero byte.
// A result goes into the output register, or into the skid entry if that is
// full. Throughput: one bit per cycle while in_tready is high; the framing
// logic is combinational between the input handshake and the output register.
// The output side has a register plus a skid entry, so in_tready stays high
// while one result waits; it drops once both entries hold a beat (a result
// arriving while out_tready is low) and rises the cycle after the receiver
// takes a beat.
// Reset (rst_n low, synchronous) clears the window, counters and phase and
// loads sync 65, start 66 and end 67. cfg_ writes take effect on the next
// cycle; the user makes them only while idle (the block does not enforce it).
module framed_message_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fmd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] rx_bit
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fmd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] out_byte, [12:8] sender_id
  output logic                               out_tuser,  // [0] out_kind
  input  logic                               cfg_we,
  input  logic [fmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fmd_pkg::BYTE_W-1:0]         cfg_wdata
);

  fmd_pkg::cfg_t cfg_r, cfg_nxt;
  logic          bit_fire;
  logic          res_valid;
  fmd_pkg::res_t res;
  fmd_pkg::res_t out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte  <= fmd_pkg::SYNC_RESET;
      cfg_r.start_byte <= fmd_pkg::START_RESET;
      cfg_r.end_byte   <= fmd_pkg::END_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        fmd_pkg::REG_SYNC:  cfg_nxt.sync_byte  = cfg_wdata;
        fmd_pkg::REG_START: cfg_nxt.start_byte = cfg_wdata;
        fmd_pkg::REG_END:   cfg_nxt.end_byte   = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  assign bit_fire = in_tvalid && in_tready;

  fmd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .bit_fire  (bit_fire),
    .rx_bit    (in_tdata[0]),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  fmd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .out_ready  (out_tready)
  );

  // pack the result beat
  assign out_tuser = out_res.kind;
  assign out_tdata = {3'b000, out_res.sender_id, out_res.data};

endmodule
